[design/egs_pkg.sv]
// shared types and constants for the epsilon-greedy selector
package egs_pkg;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] EPS_RESET   = 17'd6554;
  localparam int          DIV_STEPS   = 17;

  typedef struct packed {
    logic [15:0] source_node;
    logic [15:0] action_id;
    logic [31:0] action_value;
    logic [15:0] explore_draw;
    logic [5:0]  other_pick;
    logic        set_last;
  } in_t;

  typedef struct packed {
    logic [15:0] from_node;
    logic [15:0] target_action;
    logic [5:0]  rank_position;
    logic [16:0] probability;
    logic        probability_valid;
    logic        is_chosen;
    logic        result_last;
  } out_t;

  // one complete set handed from front to back
  typedef struct packed {
    logic [15:0] source;
    logic [15:0] explore;
    logic [5:0]  pick;
    logic [16:0] eps;
  } job_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCAN
  } back_state_t;

endpackage

[design/epsilon_greedy_selector_top.sv]
// top level of the epsilon-greedy selector: front store plus back ranking engine
// after the last beat of a set of n pairs the back runs a divide (skipped for n = 1), then
//   n scans over the stored pairs, one result per scan
// busy stays high from the last beat until the final result is on the ports
// reset: rst_n synchronous, active low; clears counts, queue and state, epsilon to 6554
// the receiver cannot stall: each result beat shows for exactly one cycle on out_strobe
module epsilon_greedy_selector_top #(
  parameter int MAX_ACTIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  egs_pkg::in_t  in_data,
  output logic          out_strobe,
  output egs_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_wdata
);

  // count width holds the store depth itself, index width addresses it
  localparam int CW = $clog2(MAX_ACTIONS + 1);
  localparam int IW = $clog2(MAX_ACTIONS);

  egs_pkg::back_stat_t bstat;
  egs_pkg::job_t       job;
  logic                job_valid;
  logic [CW-1:0]       job_n;
  logic [IW-1:0]       rd_addr;
  logic [15:0]         rd_id;
  logic [31:0]         rd_val;

  // front: takes pair beats into the store and queues a finished set
  egs_front #(.MAX_ACTIONS(MAX_ACTIONS), .CW(CW), .IW(IW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .bstat     (bstat),
    .job_valid (job_valid),
    .job       (job),
    .job_n     (job_n),
    .rd_addr   (rd_addr),
    .rd_id     (rd_id),
    .rd_val    (rd_val)
  );

  // back: ranks the stored set by repeated max scans and emits the result beats
  egs_back #(.MAX_ACTIONS(MAX_ACTIONS), .CW(CW), .IW(IW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job        (job),
    .job_n      (job_n),
    .bstat      (bstat),
    .rd_addr    (rd_addr),
    .rd_id      (rd_id),
    .rd_val     (rd_val),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

[design/egs_front.sv]
// front: pair store, epsilon register and one-deep set queue
module egs_front #(
  parameter int MAX_ACTIONS = 16,
  parameter int CW = $clog2(MAX_ACTIONS + 1),
  parameter int IW = $clog2(MAX_ACTIONS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  egs_pkg::in_t        in_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata,
  input  egs_pkg::back_stat_t bstat,
  output logic                job_valid,
  output egs_pkg::job_t       job,
  output logic [CW-1:0]       job_n,
  input  logic [IW-1:0]       rd_addr,
  output logic [15:0]         rd_id,
  output logic [31:0]         rd_val
);

  logic [15:0]    id_mem  [MAX_ACTIONS];
  logic [31:0]    val_mem [MAX_ACTIONS];
  logic [CW-1:0]  count_r, count_nxt;
  logic [16:0]    eps_r;
  logic           qv_r, qv_nxt;
  egs_pkg::job_t  job_r, job_nxt;
  logic [CW-1:0]  n_r, n_nxt;
  logic           accept, has_room;
  logic [16:0]    eps_sat;

  assign busy     = qv_r | bstat.busy;
  assign accept   = start & ~busy;
  assign has_room = count_r < CW'(MAX_ACTIONS);
  assign eps_sat  = (eps_r > egs_pkg::ONE_Q16) ? egs_pkg::ONE_Q16 : eps_r;

  always_comb begin
    count_nxt = count_r;
    qv_nxt    = qv_r & ~bstat.pop;
    job_nxt   = job_r;
    n_nxt     = n_r;
    if (accept) begin
      if (has_room) count_nxt = count_r + 1'b1;
      if (in_data.set_last) begin
        count_nxt       = '0;
        qv_nxt          = 1'b1;
        n_nxt           = has_room ? count_r + 1'b1 : count_r;
        job_nxt.source  = in_data.source_node;
        job_nxt.explore = in_data.explore_draw;
        job_nxt.pick    = in_data.other_pick;
        job_nxt.eps     = eps_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      qv_r    <= 1'b0;
      eps_r   <= egs_pkg::EPS_RESET;
    end else begin
      count_r <= count_nxt;
      qv_r    <= qv_nxt;
      if (cfg_we) eps_r <= cfg_wdata;
    end
    job_r <= job_nxt;
    n_r   <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      id_mem[count_r[IW-1:0]]  <= in_data.action_id;
      val_mem[count_r[IW-1:0]] <= in_data.action_value;
    end
    rd_id  <= id_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  assign job_valid = qv_r;
  assign job       = job_r;
  assign job_n     = n_r;

endmodule

[design/egs_back.sv]
// back: probability divider, selection-sort scan and result emission
module egs_back #(
  parameter int MAX_ACTIONS = 16,
  parameter int CW = $clog2(MAX_ACTIONS + 1),
  parameter int IW = $clog2(MAX_ACTIONS)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  egs_pkg::job_t       job,
  input  logic [CW-1:0]       job_n,
  output egs_pkg::back_stat_t bstat,
  output logic [IW-1:0]       rd_addr,
  input  logic [15:0]         rd_id,
  input  logic [31:0]         rd_val,
  output logic                out_strobe,
  output egs_pkg::out_t       out_data
);

  egs_pkg::back_state_t state_r, state_nxt;
  egs_pkg::job_t        job_r, job_nxt;
  logic [CW-1:0]        n_r, n_nxt, chosen_r, chosen_nxt, rank_r, rank_nxt, j_r, j_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [16:0]          quo_r, quo_nxt;
  logic                 rv_r, rv_nxt;
  logic [IW-1:0]        ridx_r, ridx_nxt, best_idx_r, best_idx_nxt;
  logic                 best_ok_r, best_ok_nxt;
  logic [31:0]          best_key_r, best_key_nxt;
  logic [15:0]          best_id_r, best_id_nxt;
  logic [MAX_ACTIONS-1:0] done_r, done_nxt;
  logic                 ostb_r, ostb_nxt;
  egs_pkg::out_t        od_r, od_nxt;
  logic [CW:0]          tmp, dvs;
  logic [31:0]          key;
  logic                 take;
  logic [6:0]           pick_x, lim_x;

  assign key     = {~rd_val[31], rd_val[30:0]};
  assign take    = ~done_r[ridx_r] & (~best_ok_r | (key > best_key_r));
  assign dvs     = {1'b0, n_r - 1'b1};
  assign tmp     = {rem_r, quo_r[16]};
  assign rd_addr = j_r[IW-1:0];

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    n_nxt        = n_r;
    chosen_nxt   = chosen_r;
    rank_nxt     = rank_r;
    j_nxt        = j_r;
    cnt_nxt      = cnt_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    rv_nxt       = 1'b0;
    ridx_nxt     = ridx_r;
    best_ok_nxt  = best_ok_r;
    best_idx_nxt = best_idx_r;
    best_key_nxt = best_key_r;
    best_id_nxt  = best_id_r;
    done_nxt     = done_r;
    ostb_nxt     = 1'b0;
    od_nxt       = od_r;
    bstat.pop    = 1'b0;
    bstat.busy   = state_r != egs_pkg::BK_IDLE;
    pick_x       = {1'b0, job.pick};
    lim_x        = 7'(job_n) - 7'd2;
    case (state_r)
      egs_pkg::BK_IDLE: begin
        if (job_valid) begin
          bstat.pop   = 1'b1;
          job_nxt     = job;
          n_nxt       = job_n;
          rank_nxt    = '0;
          j_nxt       = '0;
          best_ok_nxt = 1'b0;
          done_nxt    = '0;
          rem_nxt     = '0;
          quo_nxt     = job.eps;
          cnt_nxt     = '0;
          if (job_n == CW'(1) || {1'b0, job.explore} <= (egs_pkg::ONE_Q16 - job.eps))
            chosen_nxt = '0;
          else
            chosen_nxt = CW'(((pick_x > lim_x) ? lim_x : pick_x) + 7'd1);
          state_nxt = (job_n == CW'(1)) ? egs_pkg::BK_SCAN : egs_pkg::BK_DIV;
        end
      end
      egs_pkg::BK_DIV: begin
        if (tmp >= dvs) begin
          rem_nxt = CW'(tmp - dvs);
          quo_nxt = {quo_r[15:0], 1'b1};
        end else begin
          rem_nxt = tmp[CW-1:0];
          quo_nxt = {quo_r[15:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'(egs_pkg::DIV_STEPS - 1)) state_nxt = egs_pkg::BK_SCAN;
      end
      egs_pkg::BK_SCAN: begin
        if (j_r < n_r) begin
          rv_nxt   = 1'b1;
          ridx_nxt = j_r[IW-1:0];
          j_nxt    = j_r + 1'b1;
        end
        if (rv_r) begin
          if (take) begin
            best_ok_nxt  = 1'b1;
            best_idx_nxt = ridx_r;
            best_key_nxt = key;
            best_id_nxt  = rd_id;
          end
          if (CW'(ridx_r) == n_r - 1'b1) begin
            // end of pass: the winner is this rank's entry
            ostb_nxt                 = 1'b1;
            done_nxt[best_idx_nxt]   = 1'b1;
            od_nxt.from_node         = job_r.source;
            od_nxt.target_action     = best_id_nxt;
            od_nxt.rank_position     = 6'(rank_r);
            od_nxt.probability_valid = n_r != CW'(1);
            if (n_r == CW'(1))      od_nxt.probability = '0;
            else if (rank_r == '0)  od_nxt.probability = egs_pkg::ONE_Q16 - job_r.eps;
            else                    od_nxt.probability = quo_r;
            od_nxt.is_chosen         = rank_r == chosen_r;
            od_nxt.result_last       = rank_r == n_r - 1'b1;
            rank_nxt    = rank_r + 1'b1;
            best_ok_nxt = 1'b0;
            j_nxt       = '0;
            rv_nxt      = 1'b0;
            if (rank_r == n_r - 1'b1) state_nxt = egs_pkg::BK_IDLE;
          end
        end
      end
      default: state_nxt = egs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= egs_pkg::BK_IDLE;
      ostb_r  <= 1'b0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ostb_r  <= ostb_nxt;
      rv_r    <= rv_nxt;
    end
    job_r      <= job_nxt;
    n_r        <= n_nxt;
    chosen_r   <= chosen_nxt;
    rank_r     <= rank_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    ridx_r     <= ridx_nxt;
    best_ok_r  <= best_ok_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
    best_id_r  <= best_id_nxt;
    done_r     <= done_nxt;
    od_r       <= od_nxt;
  end

  assign out_strobe = ostb_r;
  assign out_data   = od_r;

endmodule

[verif/tb_epsilon_greedy_selector_top.sv]
// testbench for the epsilon-greedy selector: directed and random sets checked against a predictor
module tb_epsilon_greedy_selector_top;

  localparam int MAX_PAIRS  = 16;
  localparam int STALL_LIM  = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  egs_pkg::in_t  in_data = '0;
  logic          out_strobe;
  egs_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [16:0]   cfg_wdata = '0;

  // predictor state, mirrors the block's own store
  logic [16:0]   eps_reg;
  logic [15:0]   pair_id [MAX_PAIRS];
  logic [31:0]   pair_val [MAX_PAIRS];
  int            pair_cnt;
  egs_pkg::out_t ranked_q [$];

  int errors = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  epsilon_greedy_selector_top #(.MAX_ACTIONS(MAX_PAIRS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // work out the results of one accepted beat
  task automatic rank_set(input egs_pkg::in_t b);
    int            order [MAX_PAIRS];
    int            n, i, j, chosen, pick;
    logic [16:0]   eps, p_other;
    egs_pkg::out_t r;
    if (pair_cnt < MAX_PAIRS) begin
      pair_id[pair_cnt]  = b.action_id;
      pair_val[pair_cnt] = b.action_value;
      pair_cnt++;
    end
    if (!b.set_last) return;
    n = pair_cnt;
    pair_cnt = 0;
    // stable insertion sort, descending signed value
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && $signed(pair_val[order[j-1]]) < $signed(pair_val[i])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    eps = (eps_reg > egs_pkg::ONE_Q16) ? egs_pkg::ONE_Q16 : eps_reg;
    if (n == 1) begin
      r = '0;
      r.from_node = b.source_node;
      r.target_action = pair_id[order[0]];
      r.is_chosen = 1'b1;
      r.result_last = 1'b1;
      ranked_q.push_back(r);
      return;
    end
    if ({1'b0, b.explore_draw} <= egs_pkg::ONE_Q16 - eps) chosen = 0;
    else begin
      pick = int'(b.other_pick);
      if (pick > n - 2) pick = n - 2;
      chosen = pick + 1;
    end
    p_other = 17'(eps / (n - 1));
    for (i = 0; i < n; i++) begin
      r.from_node = b.source_node;
      r.target_action = pair_id[order[i]];
      r.rank_position = i[5:0];
      r.probability = (i == 0) ? egs_pkg::ONE_Q16 - eps : p_other;
      r.probability_valid = 1'b1;
      r.is_chosen = (i == chosen);
      r.result_last = (i == n - 1);
      ranked_q.push_back(r);
    end
  endtask

  // result checker; the receiver takes every strobed beat, sampled mid-cycle
  always @(negedge clk) begin
    egs_pkg::out_t e;
    if (rst_n && out_strobe) begin
      if (ranked_q.size() == 0) begin
        $error("unexpected result beat %p", out_data);
        errors++;
      end else begin
        e = ranked_q.pop_front();
        if (out_data.from_node !== e.from_node) begin
          $error("from_node exp %0d got %0d", e.from_node, out_data.from_node); errors++;
        end
        if (out_data.target_action !== e.target_action) begin
          $error("target_action exp %0d got %0d", e.target_action, out_data.target_action);
          errors++;
        end
        if (out_data.rank_position !== e.rank_position) begin
          $error("rank_position exp %0d got %0d", e.rank_position, out_data.rank_position);
          errors++;
        end
        if (out_data.probability !== e.probability) begin
          $error("probability exp %0d got %0d", e.probability, out_data.probability); errors++;
        end
        if (out_data.probability_valid !== e.probability_valid) begin
          $error("probability_valid exp %0d got %0d", e.probability_valid,
                 out_data.probability_valid);
          errors++;
        end
        if (out_data.is_chosen !== e.is_chosen) begin
          $error("is_chosen exp %0d got %0d", e.is_chosen, out_data.is_chosen); errors++;
        end
        if (out_data.result_last !== e.result_last) begin
          $error("result_last exp %0d got %0d", e.result_last, out_data.result_last); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(negedge clk) begin
    if ((start && !busy) || out_strobe || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one beat, with a random gap first; start stays high for back to back beats
  task automatic send_beat(input egs_pkg::in_t b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= b;
    // busy only moves at the rising edge, so mid-cycle tells whether the next edge takes it
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    rank_set(b);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_eps(input logic [16:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eps_reg = v;
  endtask

  function automatic egs_pkg::in_t rand_beat(input bit last);
    egs_pkg::in_t b;
    b.source_node  = 16'($urandom);
    b.action_id    = 16'($urandom);
    // narrow values often so ties come up
    b.action_value = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
    b.explore_draw = 16'($urandom);
    b.other_pick   = 6'($urandom_range(63));
    b.set_last     = last;
    return b;
  endfunction

  task automatic send_set(input int n);
    for (int k = 0; k < n; k++) send_beat(rand_beat(k == n - 1));
  endtask

  // single pair, extremes of the fields, ties and pick clamp
  task automatic test_directed();
    egs_pkg::in_t b;
    b = '0; b.set_last = 1'b1; send_beat(b);
    b = '1; send_beat(b);
    b = '0; b.action_id = 16'hffff; b.action_value = 32'h8000_0000; send_beat(b);
    b.action_id = 16'h0001; b.action_value = 32'h7fff_ffff; send_beat(b);
    b.action_id = 16'h0002; b.action_value = 32'h7fff_ffff; send_beat(b);
    b = '1; b.action_id = 16'h0003; b.action_value = 32'h0; send_beat(b);
    // greedy boundary: draw exactly 1 - epsilon
    b = '0; b.action_value = 32'd5; send_beat(b);
    b.action_id = 16'd9; b.explore_draw = 16'(65536 - 6554); b.set_last = 1'b1;
    send_beat(b);
    b.explore_draw = 16'(65536 - 6553); b.other_pick = 6'd0; send_beat(b);
  endtask

  // more than the store holds: extras and the last pair dropped
  task automatic test_overflow();
    send_set(MAX_PAIRS + 3);
    send_set(MAX_PAIRS);
  endtask

  task automatic test_epsilon_sweep();
    logic [16:0] vals [6] = '{17'd0, 17'd65536, 17'h1ffff, 17'd1, 17'd32768, 17'd6554};
    foreach (vals[k]) begin
      write_eps(vals[k]);
      repeat (4) send_set($urandom_range(1, 6));
    end
  endtask

  task automatic test_random(input int pct);
    int sent = 0;
    idle_pct = pct;
    while (sent < 30) begin
      int n = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 5);
      if ($urandom_range(5) == 0) write_eps(17'($urandom_range(0, 17'h1ffff)));
      send_set(n);
      sent += n;
    end
    idle_pct = 0;
    // hold off until everything is out
    wait_drained();
  endtask

  initial begin
    eps_reg = egs_pkg::EPS_RESET;
    pair_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_epsilon_sweep();
    test_random(0);
    test_random(45);
    test_random(0);
    test_random(36);
    wait_drained();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
design/egs_pkg.sv
design/egs_front.sv
design/egs_back.sv
design/epsilon_greedy_selector_top.sv
verif/tb_epsilon_greedy_selector_top.sv
